### rtl/mrmu_pkg.sv
`default_nettype none
package mrmu_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int MAX_RESULTS   = 32;
  localparam int SHOWN_MAX     = (TABLE_ENTRIES < MAX_RESULTS) ? TABLE_ENTRIES : MAX_RESULTS;

  localparam int ADDR_W  = 64;
  localparam int TYPE_W  = 32;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 6;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int WC_W    = $clog2(TABLE_ENTRIES + 2);
  localparam int PC_W    = $clog2(TABLE_ENTRIES + 5);

  typedef enum logic [1:0] {
    REQ_CLEAR     = 2'd0,
    REQ_APPEND    = 2'd1,
    REQ_OVERWRITE = 2'd2,
    REQ_READ      = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ORDER    = 2'd2
  } stat_t;

  typedef struct packed {
    logic  req_ld;
    logic  cnt_clr;
    logic  app_wr;
    logic  idx_clr;
    logic  idx_inc;
    logic  tbl_rd;
    logic  piece_ld;
    logic  feed;
    logic  flush;
    logic  mrg_clr;
    logic  wk_rd;
    logic  cp_wr;
    logic  cnt_commit;
    logic  res_ld;
    logic  res_entry;
    stat_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic end_lt_start;
    logic end_eq_start;
    logic tbl_full;
    logic cnt_zero;
    logic idx_lt_cnt;
    logic idx_last_shown;
    logic piece_pend;
    logic inserted;
    logic mrg_fail;
    logic idx_lt_wcnt;
  } dp_sts_t;

  function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_W] ? {ADDR_W{1'b1}} : s[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/memory_region_map_update.sv
`default_nettype none
// Typed address region table. One request transaction in, one or more result
// transactions out: clear, append and overwrite give one result each, read
// out gives one result per table entry (first 32 at most), or one empty
// result for an empty table; last marks the final one. Requests are handled
// one at a time: in_ready is high only while the block is idle. Clear and
// append update the entry count and table directly; read out reads one entry
// per result and waits for the output handshake before the next. Overwrite
// walks the table once through the table RAM's one registered read port:
// each stored entry is read and split, and its kept pieces are fed to the
// merge unit; then the new region is placed and flushed, and the merged
// scratch table is copied back entry by entry. These steps run in turn, as
// the table and scratch RAMs have one read port each. Table contents are not
// cleared at reset; only the entry count is, so no start-up sweep is needed.
module memory_region_map_update (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic [mrmu_pkg::ADDR_W-1:0]        in_range_start,
  input  wire logic [mrmu_pkg::ADDR_W-1:0]        in_region_length,
  input  wire logic [mrmu_pkg::ADDR_W-1:0]        in_range_end,
  input  wire logic [mrmu_pkg::TYPE_W-1:0]        in_region_type,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [mrmu_pkg::STAT_W-1:0]             out_status,
  output logic                                    out_entry_valid,
  output logic [mrmu_pkg::ADDR_W-1:0]             out_entry_base,
  output logic [mrmu_pkg::ADDR_W-1:0]             out_entry_length,
  output logic [mrmu_pkg::TYPE_W-1:0]             out_entry_type,
  output logic [mrmu_pkg::TOTAL_W-1:0]            out_entry_total,
  output logic                                    out_last
);

  mrmu_pkg::dp_cmd_t cmd;
  mrmu_pkg::dp_sts_t sts;

  // sequence the request: decode, table walk, merge, copy back, results
  mrmu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table and scratch RAMs, split and merge logic, result register
  mrmu_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_range_start   (in_range_start),
    .in_region_length (in_region_length),
    .in_range_end     (in_range_end),
    .in_region_type   (in_region_type),
    .out_status       (out_status),
    .out_entry_valid  (out_entry_valid),
    .out_entry_base   (out_entry_base),
    .out_entry_length (out_entry_length),
    .out_entry_type   (out_entry_type),
    .out_entry_total  (out_entry_total),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

### rtl/mrmu_dp.sv
`default_nettype none
module mrmu_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mrmu_pkg::dp_cmd_t                  cmd,
  output mrmu_pkg::dp_sts_t                       sts,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic [mrmu_pkg::ADDR_W-1:0]        in_range_start,
  input  wire logic [mrmu_pkg::ADDR_W-1:0]        in_region_length,
  input  wire logic [mrmu_pkg::ADDR_W-1:0]        in_range_end,
  input  wire logic [mrmu_pkg::TYPE_W-1:0]        in_region_type,
  output logic [mrmu_pkg::STAT_W-1:0]             out_status,
  output logic                                    out_entry_valid,
  output logic [mrmu_pkg::ADDR_W-1:0]             out_entry_base,
  output logic [mrmu_pkg::ADDR_W-1:0]             out_entry_length,
  output logic [mrmu_pkg::TYPE_W-1:0]             out_entry_type,
  output logic [mrmu_pkg::TOTAL_W-1:0]            out_entry_total,
  output logic                                    out_last
);

  localparam int T  = mrmu_pkg::TABLE_ENTRIES;
  localparam int AW = mrmu_pkg::ADDR_W;
  localparam int TW = mrmu_pkg::TYPE_W;
  localparam int IW = mrmu_pkg::IDX_W;
  localparam int CW = mrmu_pkg::CNT_W;
  localparam int WW = mrmu_pkg::WC_W;
  localparam int PW = mrmu_pkg::PC_W;

  // request
  mrmu_pkg::req_t req_r;
  logic [AW-1:0]  start_r, len_r, end_r;
  logic [TW-1:0]  rtype_r;

  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  idx_r;

  logic [AW-1:0]  tb_base [T];
  logic [AW-1:0]  tb_len  [T];
  logic [TW-1:0]  tb_type [T];
  logic [AW-1:0]  wk_base [T];
  logic [AW-1:0]  wk_len  [T];
  logic [TW-1:0]  wk_type [T];

  logic [AW-1:0]  rd_b_r, rd_l_r;
  logic [TW-1:0]  rd_t_r;
  logic [AW-1:0]  wr_b_r, wr_l_r;
  logic [TW-1:0]  wr_t_r;

  // pending pieces of one table entry
  logic           p0_v_r, p1_v_r;
  logic [AW-1:0]  p0_b_r, p0_l_r, p1_b_r, p1_l_r;
  logic [TW-1:0]  p0_t_r, p1_t_r;

  // merge accumulator
  logic           cur_v_r, ins_r;
  logic [AW-1:0]  cur_b_r, cur_l_r;
  logic [TW-1:0]  cur_t_r;
  logic [WW-1:0]  wcnt_r;
  logic [PW-1:0]  pcnt_r;

  always_ff @(posedge clk) begin
    if (cmd.req_ld) begin
      req_r   <= mrmu_pkg::req_t'(in_req_type);
      start_r <= in_range_start;
      len_r   <= in_region_length;
      end_r   <= in_range_end;
      rtype_r <= in_region_type;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.app_wr) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_commit) begin
      cnt_r <= CW'(wcnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // table memory: one write port, one registered read port
  logic [IW-1:0] tb_wa;
  logic [AW-1:0] tb_wb, tb_wl;
  logic [TW-1:0] tb_wt;
  logic          tb_we;

  always_comb begin
    tb_we = cmd.app_wr | cmd.cp_wr;
    if (cmd.app_wr) begin
      tb_wa = cnt_r[IW-1:0];
      tb_wb = start_r;
      tb_wl = len_r;
      tb_wt = rtype_r;
    end else begin
      tb_wa = idx_r[IW-1:0];
      tb_wb = wr_b_r;
      tb_wl = wr_l_r;
      tb_wt = wr_t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tb_we) begin
      tb_base[tb_wa] <= tb_wb;
      tb_len[tb_wa]  <= tb_wl;
      tb_type[tb_wa] <= tb_wt;
    end
    if (cmd.tbl_rd) begin
      rd_b_r <= tb_base[idx_r[IW-1:0]];
      rd_l_r <= tb_len[idx_r[IW-1:0]];
      rd_t_r <= tb_type[idx_r[IW-1:0]];
    end
  end

  // split the entry just read against the overwrite range
  logic [AW-1:0] rd_e;
  logic          outside, lo_keep, hi_keep;

  always_comb begin
    rd_e    = mrmu_pkg::sat_add(rd_b_r, rd_l_r);
    outside = (rd_e <= start_r) || (rd_b_r >= end_r);
    lo_keep = !outside && (rd_b_r < start_r);
    hi_keep = !outside && (rd_e > end_r);
  end

  // candidate for the merge unit: the new region or the head piece
  logic          pend, use_ins, abut;
  logic [AW-1:0] hd_b, hd_l, x_b, x_l;
  logic [TW-1:0] hd_t, x_t;
  logic          wk_we;

  always_comb begin
    pend    = p0_v_r | p1_v_r;
    hd_b    = p0_v_r ? p0_b_r : p1_b_r;
    hd_l    = p0_v_r ? p0_l_r : p1_l_r;
    hd_t    = p0_v_r ? p0_t_r : p1_t_r;
    use_ins = !ins_r && (!pend || (hd_b > start_r));
    x_b     = use_ins ? start_r : hd_b;
    x_l     = use_ins ? (end_r - start_r) : hd_l;
    x_t     = use_ins ? rtype_r : hd_t;
    abut    = cur_v_r && (cur_t_r == x_t) && (mrmu_pkg::sat_add(cur_b_r, cur_l_r) == x_b);
    wk_we   = cur_v_r && ((cmd.feed && !abut) || cmd.flush);
  end

  always_ff @(posedge clk) begin
    if (cmd.piece_ld) begin
      p0_b_r <= rd_b_r;
      p0_l_r <= outside ? rd_l_r : (start_r - rd_b_r);
      p0_t_r <= rd_t_r;
      p1_b_r <= end_r;
      p1_l_r <= rd_e - end_r;
      p1_t_r <= rd_t_r;
    end
    if (cmd.feed && !abut) begin
      cur_b_r <= x_b;
      cur_l_r <= x_l;
      cur_t_r <= x_t;
    end else if (cmd.feed) begin
      cur_l_r <= mrmu_pkg::sat_add(cur_l_r, x_l);
    end
    if (wk_we && (wcnt_r < WW'(T))) begin
      wk_base[wcnt_r[IW-1:0]] <= cur_b_r;
      wk_len[wcnt_r[IW-1:0]]  <= cur_l_r;
      wk_type[wcnt_r[IW-1:0]] <= cur_t_r;
    end
    if (cmd.wk_rd) begin
      wr_b_r <= wk_base[idx_r[IW-1:0]];
      wr_l_r <= wk_len[idx_r[IW-1:0]];
      wr_t_r <= wk_type[idx_r[IW-1:0]];
    end
  end

  logic [PW-1:0] pcnt_add;
  assign pcnt_add = PW'(outside) + PW'(lo_keep) + PW'(hi_keep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      cur_v_r <= 1'b0;
      ins_r   <= 1'b0;
      wcnt_r  <= '0;
      pcnt_r  <= '0;
    end else if (cmd.mrg_clr) begin
      p0_v_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      cur_v_r <= 1'b0;
      ins_r   <= 1'b0;
      wcnt_r  <= '0;
      pcnt_r  <= '0;
    end else begin
      if (cmd.piece_ld) begin
        p0_v_r <= outside | lo_keep;
        p1_v_r <= hi_keep;
        if (pcnt_r < PW'(T + 2)) begin
          pcnt_r <= pcnt_r + pcnt_add;
        end
      end
      if (cmd.feed) begin
        cur_v_r <= 1'b1;
        if (use_ins) begin
          ins_r <= 1'b1;
        end else if (p0_v_r) begin
          p0_v_r <= 1'b0;
        end else begin
          p1_v_r <= 1'b0;
        end
      end
      if (wk_we && (wcnt_r <= WW'(T))) begin
        wcnt_r <= wcnt_r + WW'(1);
      end
    end
  end

  // result register
  logic [CW-1:0] shown;
  logic          last_shown;

  always_comb begin
    shown      = (cnt_r > CW'(mrmu_pkg::SHOWN_MAX)) ? CW'(mrmu_pkg::SHOWN_MAX) : cnt_r;
    last_shown = ({1'b0, idx_r} + (CW+1)'(1)) == {1'b0, shown};
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_status       <= cmd.res_status;
      out_entry_valid  <= cmd.res_entry;
      out_entry_base   <= cmd.res_entry ? rd_b_r : '0;
      out_entry_length <= cmd.res_entry ? rd_l_r : '0;
      out_entry_type   <= cmd.res_entry ? rd_t_r : '0;
      out_entry_total  <= mrmu_pkg::TOTAL_W'(cnt_r);
      out_last         <= cmd.res_entry ? last_shown : 1'b1;
    end
  end

  always_comb begin
    sts.req            = req_r;
    sts.end_lt_start   = end_r < start_r;
    sts.end_eq_start   = end_r == start_r;
    sts.tbl_full       = cnt_r >= CW'(T);
    sts.cnt_zero       = cnt_r == '0;
    sts.idx_lt_cnt     = idx_r < cnt_r;
    sts.idx_last_shown = last_shown;
    sts.piece_pend     = pend;
    sts.inserted       = ins_r;
    sts.mrg_fail       = (pcnt_r >= PW'(T + 2)) || (wcnt_r > WW'(T));
    sts.idx_lt_wcnt    = WW'(idx_r) < wcnt_r;
  end

endmodule
`default_nettype wire

### rtl/mrmu_ctrl.sv
`default_nettype none
module mrmu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire mrmu_pkg::dp_sts_t sts,
  output mrmu_pkg::dp_cmd_t      cmd
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_DEC  = 16'h0002,
    S_OCHK = 16'h0004,
    S_ORD  = 16'h0008,
    S_OCL  = 16'h0010,
    S_OFD  = 16'h0020,
    S_OIN  = 16'h0040,
    S_OFL  = 16'h0080,
    S_OEND = 16'h0100,
    S_CCHK = 16'h0200,
    S_CRD  = 16'h0400,
    S_CWR  = 16'h0800,
    S_RES  = 16'h1000,
    S_RRD  = 16'h2000,
    S_RLD  = 16'h4000,
    S_WAIT = 16'h8000
  } state_t;

  state_t          state_r, state_nxt;
  mrmu_pkg::stat_t stat_r, stat_nxt;
  logic            rdm_r, rdm_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_WAIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stat_r  <= mrmu_pkg::ST_DONE;
      rdm_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
      rdm_r   <= rdm_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    stat_nxt       = stat_r;
    rdm_nxt        = rdm_r;
    cmd            = '0;
    cmd.res_status = stat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_ld = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        rdm_nxt  = 1'b0;
        stat_nxt = mrmu_pkg::ST_DONE;
        unique case (sts.req)
          mrmu_pkg::REQ_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_RES;
          end
          mrmu_pkg::REQ_APPEND: begin
            if (sts.tbl_full) begin
              stat_nxt = mrmu_pkg::ST_OVERFLOW;
            end else begin
              cmd.app_wr = 1'b1;
            end
            state_nxt = S_RES;
          end
          mrmu_pkg::REQ_OVERWRITE: begin
            if (sts.end_lt_start) begin
              stat_nxt  = mrmu_pkg::ST_ORDER;
              state_nxt = S_RES;
            end else if (sts.end_eq_start) begin
              state_nxt = S_RES;
            end else begin
              cmd.mrg_clr = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = S_OCHK;
            end
          end
          mrmu_pkg::REQ_READ: begin
            cmd.idx_clr = 1'b1;
            if (sts.cnt_zero) begin
              state_nxt = S_RES;
            end else begin
              rdm_nxt   = 1'b1;
              state_nxt = S_RRD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_OCHK: state_nxt = sts.idx_lt_cnt ? S_ORD : S_OIN;
      S_ORD: begin
        cmd.tbl_rd = 1'b1;
        state_nxt  = S_OCL;
      end
      S_OCL: begin
        cmd.piece_ld = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_OFD;
      end
      S_OFD: begin
        if (sts.piece_pend) begin
          cmd.feed = 1'b1;
        end else begin
          state_nxt = S_OCHK;
        end
      end
      S_OIN: begin
        cmd.feed  = !sts.inserted;
        state_nxt = S_OFL;
      end
      S_OFL: begin
        cmd.flush = 1'b1;
        state_nxt = S_OEND;
      end
      S_OEND: begin
        if (sts.mrg_fail) begin
          stat_nxt  = mrmu_pkg::ST_OVERFLOW;
          state_nxt = S_RES;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CCHK;
        end
      end
      S_CCHK: begin
        if (sts.idx_lt_wcnt) begin
          state_nxt = S_CRD;
        end else begin
          cmd.cnt_commit = 1'b1;
          state_nxt      = S_RES;
        end
      end
      S_CRD: begin
        cmd.wk_rd = 1'b1;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cmd.cp_wr   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_CCHK;
      end
      S_RES: begin
        cmd.res_ld = 1'b1;
        state_nxt  = S_WAIT;
      end
      S_RRD: begin
        cmd.tbl_rd = 1'b1;
        state_nxt  = S_RLD;
      end
      S_RLD: begin
        cmd.res_ld    = 1'b1;
        cmd.res_entry = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready) begin
          if (rdm_r && !sts.idx_last_shown) begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
